### rtl/core/assert_macros.svh
// Assertion macros shared by the page job sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  `ASSERT_AT(lbl, clk, rst, !(expr))
`else
`define ASSERT_AT(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

### rtl/core/dfpjs_pkg.sv
// Types, constants and codes shared by the page job sequencer modules.
package dfpjs_pkg;

  // Geometry of the linear space and the device page
  localparam int PAGE_BYTES     = 256;
  localparam int ADDRESS_BITS   = 20;
  localparam int LENGTH_BITS    = 16;
  localparam int OFFSET_BITS    = $clog2(PAGE_BYTES);
  localparam int PAGE_BITS      = ADDRESS_BITS - OFFSET_BITS;
  localparam int CHUNK_BITS     = OFFSET_BITS + 1;
  localparam int MIN_BITS       = (LENGTH_BITS > CHUNK_BITS) ? LENGTH_BITS : CHUNK_BITS;
  localparam int DEV_ADDR_BITS  = 24;
  localparam int DEV_PAGE_SHIFT = 9;

  // Result queue sizing
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int FIFO_COUNT_BITS = $clog2(FIFO_DEPTH + 1);
  localparam int FIFO_PUSH_LIMIT = FIFO_DEPTH - 2;

  // Device command bytes and status
  localparam logic [7:0] CMD_READ      = 8'h03;
  localparam logic [7:0] CMD_STATUS    = 8'hd7;
  localparam logic [7:0] CMD_TO_BUF    = 8'h53;
  localparam logic [7:0] CMD_BUF_WRITE = 8'h84;
  localparam logic [7:0] CMD_PROGRAM   = 8'h83;
  localparam logic [7:0] STATUS_READY  = 8'h80;
  localparam logic [7:0] DUMMY_BYTE    = 8'h00;

  // Index of the final address byte of a command header
  localparam logic [1:0] HDR_LAST = 2'd3;

  typedef enum logic [1:0] {
    KIND_READ      = 2'd0,
    KIND_WRITE     = 2'd1,
    KIND_HOST_BYTE = 2'd2,
    KIND_SPI_BYTE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ACT_SPI_SEND   = 3'd0,
    ACT_READ_DATA  = 3'd1,
    ACT_WRITE_REQ  = 3'd2,
    ACT_JOB_DONE   = 3'd3,
    ACT_JOB_REJECT = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_R_HDR, PH_R_DATA,
    PH_P1_CMD, PH_P1_STAT, PH_H53,
    PH_P2_CMD, PH_P2_STAT, PH_H84,
    PH_HOST, PH_W_DATA, PH_H83,
    PH_P3_CMD, PH_P3_STAT
  } phase_t;

  typedef struct packed {
    kind_t                   kind;
    logic [ADDRESS_BITS-1:0] address;
    logic [LENGTH_BITS-1:0]  length;
    logic [7:0]              data_byte;
  } item_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] tx_byte;
    logic       release_select;
    logic [7:0] read_byte;
    logic       last;
  } res_t;

  // Up to two results written to the queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

### rtl/core/dfpjs_input_stage.sv
// Input register holding one transaction until the sequencer takes it.
module dfpjs_input_stage (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           kind,
  input  logic [dfpjs_pkg::ADDRESS_BITS-1:0]   address,
  input  logic [dfpjs_pkg::LENGTH_BITS-1:0]    length,
  input  logic [7:0]                           data_byte,
  input  logic                                 take,
  output logic                                 item_valid,
  output dfpjs_pkg::item_t                     item
);

  logic load;

  // Stall only while a held transaction cannot move on
  assign in_stall = item_valid && !take;
  assign load     = in_valid && !in_stall;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (load) begin
      item.kind      <= dfpjs_pkg::kind_t'(kind);
      item.address   <= address;
      item.length    <= length;
      item.data_byte <= data_byte;
    end
  end

endmodule

### rtl/core/dfpjs_sequencer.sv
// Job state and single-pass decode of one transaction into up to two results.
`include "assert_macros.svh"
module dfpjs_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  dfpjs_pkg::item_t item,
  output dfpjs_pkg::push_t push
);

  dfpjs_pkg::phase_t                        phase, phase_next;
  logic [dfpjs_pkg::ADDRESS_BITS-1:0]       current_address, current_address_next;
  logic [dfpjs_pkg::LENGTH_BITS-1:0]        bytes_remaining, bytes_remaining_next;
  logic [dfpjs_pkg::CHUNK_BITS-1:0]         chunk_left, chunk_left_next;
  logic [1:0]                               header_index, header_index_next;
  logic [dfpjs_pkg::DEV_ADDR_BITS-1:0]      chunk_address, chunk_address_next;

  logic [dfpjs_pkg::CHUNK_BITS-1:0]         cl_dec;
  logic [dfpjs_pkg::LENGTH_BITS-1:0]        br_dec;
  logic [dfpjs_pkg::ADDRESS_BITS-1:0]       ca_inc;
  logic [dfpjs_pkg::ADDRESS_BITS-1:0]       src_addr;
  logic [dfpjs_pkg::LENGTH_BITS-1:0]        src_rem;
  logic [dfpjs_pkg::OFFSET_BITS-1:0]        src_off;
  logic [dfpjs_pkg::PAGE_BITS-1:0]          src_page;
  logic [dfpjs_pkg::CHUNK_BITS-1:0]         room;
  logic [dfpjs_pkg::DEV_ADDR_BITS-1:0]      new_chunk_address;
  logic [dfpjs_pkg::CHUNK_BITS-1:0]         new_chunk_left;
  logic [1:0]                               hi_inc;
  logic                                     hdr_more;
  logic                                     is_start;
  logic                                     ready;
  logic [7:0]                               next_addr_byte;
  logic [1:0]                               cnt;
  dfpjs_pkg::res_t                          r0, r1;
  logic                                     to_idle;
  logic                                     done_out;
  logic                                     hdr_phase;
  logic                                     data_phase;

  function automatic dfpjs_pkg::res_t mk_send(input logic [7:0] tx, input logic rel);
    dfpjs_pkg::res_t r;
    r = '0;
    r.action         = dfpjs_pkg::ACT_SPI_SEND;
    r.tx_byte        = tx;
    r.release_select = rel;
    return r;
  endfunction

  function automatic dfpjs_pkg::res_t mk_event(input dfpjs_pkg::action_t act,
                                               input logic [7:0] rb);
    dfpjs_pkg::res_t r;
    r = '0;
    r.action    = act;
    r.read_byte = rb;
    return r;
  endfunction

  // Consume one data byte
  assign cl_dec = chunk_left - 1'b1;
  assign br_dec = (bytes_remaining != '0) ? bytes_remaining - 1'b1 : '0;
  assign ca_inc = current_address + 1'b1;

  // Pick where the next chunk starts: new job, after a read byte, or as stored
  always_comb begin
    if (phase == dfpjs_pkg::PH_IDLE) begin
      src_addr = item.address;
      src_rem  = item.length;
    end else if (phase == dfpjs_pkg::PH_R_DATA) begin
      src_addr = ca_inc;
      src_rem  = br_dec;
    end else begin
      src_addr = current_address;
      src_rem  = bytes_remaining;
    end
  end

  // Split the start address into page and offset, clip the chunk to the page
  assign src_off  = src_addr[dfpjs_pkg::OFFSET_BITS-1:0];
  assign src_page = src_addr[dfpjs_pkg::ADDRESS_BITS-1:dfpjs_pkg::OFFSET_BITS];
  assign room     = dfpjs_pkg::CHUNK_BITS'(dfpjs_pkg::PAGE_BYTES)
                  - dfpjs_pkg::CHUNK_BITS'(src_off);
  assign new_chunk_address =
      (dfpjs_pkg::DEV_ADDR_BITS'(src_page) << dfpjs_pkg::DEV_PAGE_SHIFT)
    | dfpjs_pkg::DEV_ADDR_BITS'(src_off);
  assign new_chunk_left =
      (dfpjs_pkg::MIN_BITS'(src_rem) < dfpjs_pkg::MIN_BITS'(room))
    ? dfpjs_pkg::CHUNK_BITS'(src_rem) : room;

  // Header byte sequencing
  assign hi_inc   = header_index + 1'b1;
  assign hdr_more = header_index != dfpjs_pkg::HDR_LAST;
  assign is_start = (item.kind == dfpjs_pkg::KIND_READ) || (item.kind == dfpjs_pkg::KIND_WRITE);
  assign ready    = (item.data_byte & dfpjs_pkg::STATUS_READY) != 8'h00;

  // Select the address byte sent after the current header byte
  always_comb begin
    case (hi_inc)
      2'd1:    next_addr_byte = chunk_address[23:16];
      2'd2:    next_addr_byte = chunk_address[15:8];
      default: next_addr_byte = chunk_address[7:0];
    endcase
  end

  // Next state
  always_comb begin
    phase_next           = phase;
    current_address_next = current_address;
    bytes_remaining_next = bytes_remaining;
    chunk_left_next      = chunk_left;
    header_index_next    = header_index;
    chunk_address_next   = chunk_address;
    if (fire) begin
      if (is_start) begin
        if (phase == dfpjs_pkg::PH_IDLE) begin
          current_address_next = item.address;
          bytes_remaining_next = item.length;
          if (item.length == '0) begin
            chunk_left_next = '0;
          end else begin
            chunk_address_next = new_chunk_address;
            chunk_left_next    = new_chunk_left;
            header_index_next  = 2'd0;
            phase_next = (item.kind == dfpjs_pkg::KIND_READ) ?
                         dfpjs_pkg::PH_R_HDR : dfpjs_pkg::PH_P1_CMD;
          end
        end
      end else if (item.kind == dfpjs_pkg::KIND_HOST_BYTE) begin
        if (phase == dfpjs_pkg::PH_HOST) begin
          phase_next = dfpjs_pkg::PH_W_DATA;
        end
      end else begin
        case (phase)
          dfpjs_pkg::PH_R_HDR: begin
            if (hdr_more) begin
              header_index_next = hi_inc;
            end else begin
              header_index_next = 2'd0;
              phase_next        = dfpjs_pkg::PH_R_DATA;
            end
          end
          dfpjs_pkg::PH_R_DATA: begin
            chunk_left_next      = cl_dec;
            bytes_remaining_next = br_dec;
            current_address_next = ca_inc;
            if (cl_dec == '0) begin
              if (br_dec == '0) begin
                phase_next = dfpjs_pkg::PH_IDLE;
              end else begin
                chunk_address_next = new_chunk_address;
                chunk_left_next    = new_chunk_left;
                header_index_next  = 2'd0;
                phase_next         = dfpjs_pkg::PH_R_HDR;
              end
            end
          end
          dfpjs_pkg::PH_P1_CMD: phase_next = dfpjs_pkg::PH_P1_STAT;
          dfpjs_pkg::PH_P2_CMD: phase_next = dfpjs_pkg::PH_P2_STAT;
          dfpjs_pkg::PH_P3_CMD: phase_next = dfpjs_pkg::PH_P3_STAT;
          dfpjs_pkg::PH_P1_STAT: begin
            header_index_next = 2'd0;
            phase_next = ready ? dfpjs_pkg::PH_H53 : dfpjs_pkg::PH_P1_CMD;
          end
          dfpjs_pkg::PH_P2_STAT: begin
            header_index_next = 2'd0;
            phase_next = ready ? dfpjs_pkg::PH_H84 : dfpjs_pkg::PH_P2_CMD;
          end
          dfpjs_pkg::PH_P3_STAT: begin
            if (!ready) begin
              phase_next = dfpjs_pkg::PH_P3_CMD;
            end else if (bytes_remaining == '0) begin
              phase_next = dfpjs_pkg::PH_IDLE;
            end else begin
              chunk_address_next = new_chunk_address;
              chunk_left_next    = new_chunk_left;
              phase_next         = dfpjs_pkg::PH_P1_CMD;
            end
          end
          dfpjs_pkg::PH_H53: begin
            if (hdr_more) begin
              header_index_next = hi_inc;
            end else begin
              header_index_next = 2'd0;
              phase_next        = dfpjs_pkg::PH_P2_CMD;
            end
          end
          dfpjs_pkg::PH_H84: begin
            if (hdr_more) begin
              header_index_next = hi_inc;
            end else begin
              header_index_next = 2'd0;
              phase_next        = dfpjs_pkg::PH_HOST;
            end
          end
          dfpjs_pkg::PH_W_DATA: begin
            chunk_left_next      = cl_dec;
            bytes_remaining_next = br_dec;
            current_address_next = ca_inc;
            header_index_next    = 2'd0;
            phase_next = (cl_dec != '0) ? dfpjs_pkg::PH_HOST : dfpjs_pkg::PH_H83;
          end
          dfpjs_pkg::PH_H83: begin
            if (hdr_more) begin
              header_index_next = hi_inc;
            end else begin
              header_index_next = 2'd0;
              phase_next        = dfpjs_pkg::PH_P3_CMD;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Results of this transaction
  always_comb begin
    cnt = 2'd0;
    r0  = '0;
    r1  = '0;
    if (fire) begin
      if (is_start) begin
        cnt = 2'd1;
        if (phase != dfpjs_pkg::PH_IDLE) begin
          r0 = mk_event(dfpjs_pkg::ACT_JOB_REJECT, 8'h00);
        end else if (item.length == '0) begin
          r0 = mk_event(dfpjs_pkg::ACT_JOB_DONE, 8'h00);
        end else if (item.kind == dfpjs_pkg::KIND_READ) begin
          r0 = mk_send(dfpjs_pkg::CMD_READ, 1'b0);
        end else begin
          r0 = mk_send(dfpjs_pkg::CMD_STATUS, 1'b0);
        end
      end else if (item.kind == dfpjs_pkg::KIND_HOST_BYTE) begin
        if (phase == dfpjs_pkg::PH_HOST) begin
          cnt = 2'd1;
          r0  = mk_send(item.data_byte, chunk_left == dfpjs_pkg::CHUNK_BITS'(1));
        end
      end else begin
        case (phase)
          dfpjs_pkg::PH_R_HDR: begin
            cnt = 2'd1;
            r0  = hdr_more ? mk_send(next_addr_byte, 1'b0)
                : mk_send(dfpjs_pkg::DUMMY_BYTE, chunk_left == dfpjs_pkg::CHUNK_BITS'(1));
          end
          dfpjs_pkg::PH_R_DATA: begin
            cnt = 2'd2;
            r0  = mk_event(dfpjs_pkg::ACT_READ_DATA, item.data_byte);
            if (cl_dec != '0) begin
              r1 = mk_send(dfpjs_pkg::DUMMY_BYTE, cl_dec == dfpjs_pkg::CHUNK_BITS'(1));
            end else if (br_dec == '0) begin
              r1 = mk_event(dfpjs_pkg::ACT_JOB_DONE, 8'h00);
            end else begin
              r1 = mk_send(dfpjs_pkg::CMD_READ, 1'b0);
            end
          end
          dfpjs_pkg::PH_P1_CMD, dfpjs_pkg::PH_P2_CMD, dfpjs_pkg::PH_P3_CMD: begin
            cnt = 2'd1;
            r0  = mk_send(dfpjs_pkg::DUMMY_BYTE, 1'b1);
          end
          dfpjs_pkg::PH_P1_STAT: begin
            cnt = 2'd1;
            r0  = mk_send(ready ? dfpjs_pkg::CMD_TO_BUF : dfpjs_pkg::CMD_STATUS, 1'b0);
          end
          dfpjs_pkg::PH_P2_STAT: begin
            cnt = 2'd1;
            r0  = mk_send(ready ? dfpjs_pkg::CMD_BUF_WRITE : dfpjs_pkg::CMD_STATUS, 1'b0);
          end
          dfpjs_pkg::PH_P3_STAT: begin
            cnt = 2'd1;
            if (ready && bytes_remaining == '0) begin
              r0 = mk_event(dfpjs_pkg::ACT_JOB_DONE, 8'h00);
            end else begin
              r0 = mk_send(dfpjs_pkg::CMD_STATUS, 1'b0);
            end
          end
          dfpjs_pkg::PH_H53, dfpjs_pkg::PH_H83: begin
            cnt = 2'd1;
            r0  = hdr_more ? mk_send(next_addr_byte, hi_inc == dfpjs_pkg::HDR_LAST)
                : mk_send(dfpjs_pkg::CMD_STATUS, 1'b0);
          end
          dfpjs_pkg::PH_H84: begin
            cnt = 2'd1;
            r0  = hdr_more ? mk_send(next_addr_byte, 1'b0)
                : mk_event(dfpjs_pkg::ACT_WRITE_REQ, 8'h00);
          end
          dfpjs_pkg::PH_W_DATA: begin
            cnt = 2'd1;
            r0  = (cl_dec != '0) ? mk_event(dfpjs_pkg::ACT_WRITE_REQ, 8'h00)
                : mk_send(dfpjs_pkg::CMD_PROGRAM, 1'b0);
          end
          default: ;
        endcase
      end
    end
    // Mark the final result of the transaction
    if (cnt == 2'd1) begin
      r0.last = 1'b1;
    end
    if (cnt == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  assign push.count  = cnt;
  assign push.first  = r0;
  assign push.second = r1;

  // Hold job state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= dfpjs_pkg::PH_IDLE;
      current_address <= '0;
      bytes_remaining <= '0;
      chunk_left      <= '0;
      header_index    <= 2'd0;
      chunk_address   <= '0;
    end else begin
      phase           <= phase_next;
      current_address <= current_address_next;
      bytes_remaining <= bytes_remaining_next;
      chunk_left      <= chunk_left_next;
      header_index    <= header_index_next;
      chunk_address   <= chunk_address_next;
    end
  end

  // Conditions watched by the checks below
  assign to_idle    = fire && phase != dfpjs_pkg::PH_IDLE && phase_next == dfpjs_pkg::PH_IDLE;
  assign done_out   = r0.action == dfpjs_pkg::ACT_JOB_DONE
                   || r1.action == dfpjs_pkg::ACT_JOB_DONE;
  assign hdr_phase  = phase == dfpjs_pkg::PH_R_HDR || phase == dfpjs_pkg::PH_H53
                   || phase == dfpjs_pkg::PH_H84 || phase == dfpjs_pkg::PH_H83;
  assign data_phase = phase == dfpjs_pkg::PH_R_DATA || phase == dfpjs_pkg::PH_HOST
                   || phase == dfpjs_pkg::PH_W_DATA;

  `ASSERT_AT(a_idle_only_on_done, clk, rst, to_idle |-> done_out)
  `ASSERT_AT(a_header_phase, clk, rst, header_index != 2'd0 |-> hdr_phase)
  `ASSERT_AT(a_chunk_pending, clk, rst, data_phase |-> chunk_left != '0)

endmodule

### rtl/core/dfpjs_result_fifo.sv
// Small result queue taking up to two results a cycle and delivering one while the output is not stalled.
`include "assert_macros.svh"
module dfpjs_result_fifo (
  input  logic             clk,
  input  logic             rst,
  input  dfpjs_pkg::push_t push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_stall,
  output dfpjs_pkg::res_t  head
);

  dfpjs_pkg::res_t                         entries [dfpjs_pkg::FIFO_DEPTH];
  logic [dfpjs_pkg::FIFO_PTR_BITS-1:0]     wr_ptr, wr_ptr_next, wr_ptr_1;
  logic [dfpjs_pkg::FIFO_PTR_BITS-1:0]     rd_ptr, rd_ptr_next;
  logic [dfpjs_pkg::FIFO_COUNT_BITS-1:0]   count, count_next;
  logic                                    pop;

  assign out_valid = count != '0;
  assign head      = entries[rd_ptr];
  assign pop       = out_valid && !out_stall;
  assign room      = count <= dfpjs_pkg::FIFO_COUNT_BITS'(dfpjs_pkg::FIFO_PUSH_LIMIT);
  assign wr_ptr_1  = wr_ptr + 1'b1;

  // Advance pointers and occupancy
  assign wr_ptr_next = wr_ptr + dfpjs_pkg::FIFO_PTR_BITS'(push.count);
  assign rd_ptr_next = rd_ptr + dfpjs_pkg::FIFO_PTR_BITS'(pop);
  assign count_next  = count + dfpjs_pkg::FIFO_COUNT_BITS'(push.count)
                     - dfpjs_pkg::FIFO_COUNT_BITS'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_1] <= push.second;
    end
  end

  `ASSERT_AT(a_push_has_room, clk, rst, push.count != 2'd0 |-> room)
  `ASSERT_NEVER(a_no_overflow, clk, rst, count > dfpjs_pkg::FIFO_COUNT_BITS'(dfpjs_pkg::FIFO_DEPTH))
  `ASSERT_AT(a_stall_holds, clk, rst, out_valid && out_stall |=> out_valid && $stable(head))

endmodule

### rtl/core/dataflash_page_job_sequencer_core.sv
// Top level of the page job sequencer: input register, sequencer and result queue.
// Page job sequencer for a serial DataFlash device. Each input transaction
// (job start, host write byte or SPI received byte) is captured in an input
// register and decoded from there into zero, one or two results, which
// go into a four-entry result queue; a result passes through the input
// register and the result queue before it appears on the output port. A new
// transaction can be accepted every cycle while the input is not stalled.
// Input stall rises only while the queue has fewer than two free entries, so
// the sustained rate is set by the single output port: one transaction per
// cycle while each gives at most one result and the output is not stalled,
// and a read data byte that also launches the next SPI byte gives two results.
// Jobs are split at page boundaries; a job start while a job is running is
// answered with a reject and does not disturb the running job.
module dataflash_page_job_sequencer_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         kind,
  input  logic [dfpjs_pkg::ADDRESS_BITS-1:0] address,
  input  logic [dfpjs_pkg::LENGTH_BITS-1:0]  length,
  input  logic [7:0]                         data_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         action,
  output logic [7:0]                         tx_byte,
  output logic                               release_select,
  output logic [7:0]                         read_byte,
  output logic                               last
);

  logic             item_valid;
  logic             room;
  logic             take;
  dfpjs_pkg::item_t item;
  dfpjs_pkg::push_t push;
  dfpjs_pkg::res_t  head;

  // Process the held transaction when the queue can take two results
  assign take = item_valid && room;

  dfpjs_input_stage u_input (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .address    (address),
    .length     (length),
    .data_byte  (data_byte),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  dfpjs_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .fire (take),
    .item (item),
    .push (push)
  );

  dfpjs_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // Drive result fields from the queue head
  assign action         = head.action;
  assign tx_byte        = head.tx_byte;
  assign release_select = head.release_select;
  assign read_byte      = head.read_byte;
  assign last           = head.last;

endmodule
